/* rtl/modular_exponentiation_top_defines.svh */
// Assertion macros for the checker file.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// Clocked property, switched off while reset is high.
`define MEXP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mexp assertion failed");

// Clocked property that also holds during reset.
`define MEXP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mexp assertion failed");

`endif

/* rtl/mexp_pkg.sv */
package mexp_pkg;

   localparam int OPERAND_WIDTH = 64;
   localparam int CNT_W         = $clog2(OPERAND_WIDTH);

   typedef logic [OPERAND_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE_GO,
      ST_REDUCE_WAIT,
      ST_CHECK,
      ST_MUL_WAIT,
      ST_SQR_GO,
      ST_SQR_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     start;
      word_type a;
      word_type b;
   } mmul_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } mmul_rsp_type;

endpackage

/* rtl/mexp_if.sv */
interface mexp_req_if;
   logic              valid;
   logic              ready;
   mexp_pkg::word_type base;
   mexp_pkg::word_type exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if;
   logic              valid;
   logic              ready;
   mexp_pkg::word_type power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);
endinterface

/* rtl/mexp_modmul.sv */
// Interleaved modular multiplier: one bit of b per cycle, MSB first.
// Each step: acc = (2*acc + bit*a) mod n, with a, acc < n.
module mexp_modmul (
   input  logic                   clock,
   input  logic                   reset,
   input  mexp_pkg::word_type     modulus,
   input  mexp_pkg::mmul_req_type req,
   output mexp_pkg::mmul_rsp_type rsp
);

   localparam int W = mexp_pkg::OPERAND_WIDTH;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [mexp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   mexp_pkg::word_type       acc_ff, acc_in;
   mexp_pkg::word_type       a_ff, a_in;
   mexp_pkg::word_type       b_ff, b_in;

   logic [W+1:0] sum;
   logic [W+1:0] n1;
   logic [W+1:0] n2;
   logic [W+1:0] red;

   // sum < 3n, so at most one of n or 2n comes off
   always_comb begin
      n1  = {2'b00, modulus};
      n2  = {1'b0, modulus, 1'b0};
      sum = {1'b0, acc_ff, 1'b0} + (b_ff[W-1] ? {2'b00, a_ff} : '0);
      if (sum >= n2) begin
         red = sum - n2;
      end else if (sum >= n1) begin
         red = sum - n1;
      end else begin
         red = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = mexp_pkg::CNT_W'(W - 1);
         acc_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
      end else if (busy_ff) begin
         acc_in = red[W-1:0];
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

/* rtl/modular_exponentiation_top.sv */
// Modular exponentiation, right-to-left binary square-and-multiply.
// req_ch carries base and exponent (valid/ready); rsp_ch returns power =
// base^exponent mod modulus (valid/ready). csr_wr_en/csr_wr_data write the
// modulus; write it only while no item is in flight.
// One item is worked at a time: req_ch.ready is high only while idle.
// Every step goes through one shared interleaved modular multiplier. The
// base is first reduced with one pass of that unit, then each exponent bit
// below the highest set bit costs a square, and each set bit a multiply.
// Exponent 0 gives 1, and a modulus below 2 gives 0.
// The finished power sits in an output register; a new item is accepted
// while it waits. If the receiver stalls, the next result is held inside
// until the register frees up.
// Reset (synchronous, active high) sets the modulus to 2, drops rsp valid
// and returns the sequencer to idle.
module modular_exponentiation_top (
   input  logic               clock,
   input  logic               reset,
   mexp_req_if.sink           req_ch,
   mexp_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  mexp_pkg::word_type csr_wr_data
);

   localparam int W = mexp_pkg::OPERAND_WIDTH;

   mexp_pkg::state_type state_ff, state_in;
   mexp_pkg::word_type  modulus_ff;
   mexp_pkg::word_type  acc_ff, acc_in;
   mexp_pkg::word_type  sq_ff, sq_in;
   mexp_pkg::word_type  exp_ff, exp_in;
   mexp_pkg::word_type  power_ff, power_in;
   logic                rsp_valid_ff, rsp_valid_in;

   mexp_pkg::mmul_req_type mm_req;
   mexp_pkg::mmul_rsp_type mm_rsp;

   logic req_fire;
   logic out_free;
   logic mod_small;
   logic exp_last;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign mod_small = (modulus_ff < W'(2));
   assign exp_last  = (exp_ff[W-1:1] == '0);

   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .req     (mm_req),
      .rsp     (mm_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = mod_small ? mexp_pkg::ST_OUT : mexp_pkg::ST_REDUCE_GO;
            end
         end
         mexp_pkg::ST_REDUCE_GO: state_in = mexp_pkg::ST_REDUCE_WAIT;
         mexp_pkg::ST_REDUCE_WAIT: begin
            if (mm_rsp.done) state_in = mexp_pkg::ST_CHECK;
         end
         mexp_pkg::ST_CHECK: begin
            if (exp_ff == '0) begin
               state_in = mexp_pkg::ST_OUT;
            end else if (exp_ff[0]) begin
               state_in = mexp_pkg::ST_MUL_WAIT;
            end else begin
               state_in = mexp_pkg::ST_SQR_WAIT;
            end
         end
         mexp_pkg::ST_MUL_WAIT: begin
            if (mm_rsp.done) begin
               state_in = exp_last ? mexp_pkg::ST_OUT : mexp_pkg::ST_SQR_GO;
            end
         end
         mexp_pkg::ST_SQR_GO: state_in = mexp_pkg::ST_SQR_WAIT;
         mexp_pkg::ST_SQR_WAIT: begin
            if (mm_rsp.done) state_in = mexp_pkg::ST_CHECK;
         end
         mexp_pkg::ST_OUT: begin
            if (out_free) state_in = mexp_pkg::ST_IDLE;
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ch.ready = (state_ff == mexp_pkg::ST_IDLE);
      mm_req.start = 1'b0;
      mm_req.a     = sq_ff;
      mm_req.b     = sq_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_fire) begin
               acc_in = mod_small ? '0 : W'(1);
               sq_in  = req_ch.base;
               exp_in = req_ch.exponent;
            end
         end
         mexp_pkg::ST_REDUCE_GO: begin
            // base mod n as 1 * base mod n
            mm_req.start = 1'b1;
            mm_req.a     = W'(1);
            mm_req.b     = sq_ff;
         end
         mexp_pkg::ST_REDUCE_WAIT: begin
            if (mm_rsp.done) sq_in = mm_rsp.result;
         end
         mexp_pkg::ST_CHECK: begin
            if (exp_ff != '0) begin
               mm_req.start = 1'b1;
               if (exp_ff[0]) mm_req.a = acc_ff;
            end
         end
         mexp_pkg::ST_MUL_WAIT: begin
            if (mm_rsp.done) acc_in = mm_rsp.result;
         end
         mexp_pkg::ST_SQR_GO: mm_req.start = 1'b1;
         mexp_pkg::ST_SQR_WAIT: begin
            if (mm_rsp.done) begin
               sq_in  = mm_rsp.result;
               exp_in = {1'b0, exp_ff[W-1:1]};
            end
         end
         mexp_pkg::ST_OUT: begin
            if (out_free) begin
               power_in     = acc_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= W'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) modulus_ff <= csr_wr_data;
      end
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      exp_ff   <= exp_in;
      power_ff <= power_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.power = power_ff;

endmodule

/* rtl/mexp_checker.sv */
`include "modular_exponentiation_top_defines.svh"

module mexp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mexp_pkg::word_type rsp_power
);

   // a stalled result stays offered
   `MEXP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // and keeps its value
   `MEXP_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_power))

   // one item at a time: busy right after an accept
   `MEXP_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready)

   // reset leaves the block idle with nothing to deliver
   `MEXP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_ready && !rsp_valid)

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_power (rsp_ch.power)
);

/* test/tb_modular_exponentiation_top.sv */
`timescale 1ns / 100ps

module tb_modular_exponentiation_top;

   localparam int  CLK_HALF    = 6;
   localparam int  IDLE_PCT    = 32;
   localparam int  CYCLE_LIMIT = 5_000_000;
   localparam int  DRAIN_WAIT  = 9000;
   localparam int  OW          = mexp_pkg::OPERAND_WIDTH;
   localparam mexp_pkg::word_type ALL_ONES = '1;

   typedef struct packed {
      mexp_pkg::word_type base;
      mexp_pkg::word_type exponent;
   } job_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   mexp_pkg::word_type csr_wr_data;

   mexp_req_if req_if ();
   mexp_rsp_if rsp_if ();

   modular_exponentiation_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   job_type            job_q[$];
   mexp_pkg::word_type power_q[$];
   int                 jobs_unaccepted = 0;
   int                 errors = 0;
   int                 cycle_count = 0;
   bit                 steady = 1'b0;
   logic               req_fire = 1'b0;
   mexp_pkg::word_type modulus_copy = 64'd2;
   mexp_pkg::word_type want_power;

   // base^exp mod n, full double-width products
   function automatic mexp_pkg::word_type mod_pow(mexp_pkg::word_type b,
                                                  mexp_pkg::word_type e,
                                                  mexp_pkg::word_type n);
      logic [2*OW-1:0] wide_n;
      logic [2*OW-1:0] sq;
      logic [2*OW-1:0] acc;
      if (n < 64'd2) return '0;
      wide_n = {{OW{1'b0}}, n};
      sq     = {{OW{1'b0}}, b} % wide_n;
      acc    = (2*OW)'(1);
      for (int i = 0; i < OW; i++) begin
         if (e[i]) acc = (acc * sq) % wide_n;
         sq = (sq * sq) % wide_n;
      end
      return acc[OW-1:0];
   endfunction

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // sender: next item goes out once the previous one has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (job_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_if.valid    <= 1'b1;
            req_if.base     <= job_q[0].base;
            req_if.exponent <= job_q[0].exponent;
            void'(job_q.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, power_q.size());
         $display("Simulation FAILED");
         $finish;
      end else if (reset) begin
         req_fire <= 1'b0;
         modulus_copy = 64'd2;
      end else begin
         if (csr_wr_en) modulus_copy = csr_wr_data;
         req_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            power_q.insert(power_q.size(),
                           mod_pow(req_if.base, req_if.exponent, modulus_copy));
            jobs_unaccepted--;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (power_q.size() == 0) begin
               $display("%0t: unexpected item, power %h", $time, rsp_if.power);
               errors++;
            end else begin
               want_power = power_q.pop_front();
               if (rsp_if.power !== want_power) begin
                  $display("%0t: power mismatch, expected %h, got %h",
                           $time, want_power, rsp_if.power);
                  errors++;
               end
            end
         end
      end
   end

   task automatic add_job(mexp_pkg::word_type b, mexp_pkg::word_type e);
      job_type j;
      j.base     = b;
      j.exponent = e;
      jobs_unaccepted++;
      job_q.insert(job_q.size(), j);
   endtask

   // all items taken and all results back
   task automatic wait_idle();
      do @(negedge clock); while (jobs_unaccepted != 0 || power_q.size() != 0);
   endtask

   task automatic set_modulus(mexp_pkg::word_type n);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly short exponents to keep the run short; a few full-width ones
   task automatic random_phase(mexp_pkg::word_type n, int count);
      mexp_pkg::word_type b;
      mexp_pkg::word_type e;
      int                 w;
      int                 kind;
      set_modulus(n);
      repeat (count) begin
         kind = $urandom_range(9);
         case (kind)
            0:       b = '0;
            1:       b = (n == '0) ? '0 : n - 64'd1;
            2:       b = 64'd1;
            default: b = {$urandom, $urandom};
         endcase
         e    = {$urandom, $urandom};
         kind = $urandom_range(9);
         if (kind <= 6) begin
            w = $urandom_range(16, 1);
         end else if (kind <= 8) begin
            w = $urandom_range(63, 17);
         end else begin
            w = 64;
         end
         if (w < 64) e = e & ((64'd1 << w) - 64'd1);
         add_job(b, e);
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_if.valid = 1'b0;
      req_if.base  = '0;
      req_if.exponent = '0;
      rsp_if.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // modulus at its reset value
      add_job('0, '0);
      add_job(ALL_ONES, ALL_ONES);
      add_job(64'd6, 64'd3);
      add_job(64'd5, 64'd0);

      set_modulus(ALL_ONES);
      add_job('0, '0);
      add_job('0, 64'd9);
      add_job(ALL_ONES, 64'd3);            // base equal to modulus
      add_job(ALL_ONES - 64'd1, ALL_ONES);
      add_job(64'd2, 64'd64);
      add_job(64'd1, ALL_ONES);
      add_job(64'd123456789, 64'd2);

      // zero and one modulus give 0, even for a zero exponent
      set_modulus('0);
      add_job(64'd5, 64'd3);
      add_job('0, '0);
      set_modulus(64'd1);
      add_job(64'd7, 64'd0);
      add_job(64'd7, 64'd9);

      set_modulus(64'd97);
      add_job(64'd200, 64'd96);
      add_job(64'd97, 64'd0);
      add_job(64'd97, 64'd5);
      add_job(64'd96, 64'd1);

      steady = 1'b1;
      random_phase({$urandom, $urandom} | 64'h8000_0000_0000_0000, 20);
      wait_idle();
      steady = 1'b0;
      random_phase(64'h8000_0000_0000_0000, 20);
      random_phase({32'd0, $urandom} | 64'd2, 20);
      random_phase(mexp_pkg::word_type'($urandom_range(1000, 2)), 20);
      random_phase(ALL_ONES, 10);
      random_phase(64'd2, 10);

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && power_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
